// ----- rtl/core/dspm_pkg.sv -----
`default_nettype none
package dspm_pkg;

    localparam int DIM        = 4;
    localparam int PRIME      = 17;
    localparam int MAX_TERMS  = 16;
    localparam int PHI        = PRIME - 1;
    localparam int CELLS      = DIM * DIM * PHI;
    localparam int X_W        = $clog2(DIM);
    localparam int W_W        = $clog2(PHI);
    localparam int IDX_W      = $clog2(CELLS);
    localparam int T_W        = $clog2(MAX_TERMS);
    localparam int CNT_W      = 5;
    localparam int FIFO_DEPTH = 2;
    localparam int FP_W       = $clog2(FIFO_DEPTH);

    localparam logic [31:0] MOD_RESET = 32'd65537;
    localparam logic [31:0] MOD_MIN   = 32'd2;

    typedef enum logic [1:0] {
        OP_LOAD_DENSE = 2'd0,
        OP_LOAD_TERM  = 2'd1,
        OP_RUN        = 2'd2,
        OP_READ       = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        rej;
        logic [7:0]  slot;
        logic [31:0] coef_real;
        logic [31:0] coef_imag;
        logic [1:0]  term_x;
        logic [1:0]  term_y;
        logic [3:0]  term_w;
        logic [63:0] term_re;
        logic [63:0] term_im;
        logic [4:0]  term_count;
    } t_item;

endpackage
`default_nettype wire

// ----- rtl/core/dspm_front.sv -----
`default_nettype none
module dspm_front import dspm_pkg::*; (
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [215:0] i_s_tdata,
    input  wire logic [1:0]   i_s_tuser,
    input  wire logic [31:0]  i_modulus,
    input  wire logic         i_fifo_full,
    output logic              o_push,
    output t_item             o_item
);

    t_item item;

    always_comb begin
        item.op         = t_op'(i_s_tuser);
        item.slot       = i_s_tdata[7:0];
        item.coef_real  = i_s_tdata[39:8];
        item.coef_imag  = i_s_tdata[71:40];
        item.term_x     = i_s_tdata[73:72];
        item.term_y     = i_s_tdata[75:74];
        item.term_w     = i_s_tdata[79:76];
        item.term_re    = i_s_tdata[143:80];
        item.term_im    = i_s_tdata[207:144];
        item.term_count = i_s_tdata[212:208];
        // range checks done here so the back end only sees a reject flag
        unique case (item.op)
            OP_LOAD_DENSE: item.rej = (32'(item.slot) >= 32'(CELLS))
                                   || (item.coef_real >= i_modulus)
                                   || (item.coef_imag >= i_modulus);
            OP_LOAD_TERM:  item.rej = (32'(item.slot) >= 32'(MAX_TERMS))
                                   || (32'(item.term_x) >= 32'(DIM))
                                   || (32'(item.term_y) >= 32'(DIM))
                                   || (32'(item.term_w) >= 32'(PHI));
            OP_RUN:        item.rej = 32'(item.term_count) > 32'(MAX_TERMS);
            OP_READ:       item.rej = 32'(item.slot) >= 32'(CELLS);
            default:       item.rej = 1'b1;
        endcase
    end

    assign o_s_tready = !i_fifo_full;
    assign o_push     = i_s_tvalid && !i_fifo_full;
    assign o_item     = item;

endmodule
`default_nettype wire

// ----- rtl/core/dspm_fifo.sv -----
`default_nettype none
module dspm_fifo import dspm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    t_item             r_mem [FIFO_DEPTH];
    logic [FP_W-1:0]   r_wp;
    logic [FP_W-1:0]   r_rp;
    logic [FP_W:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= r_wp + 1'b1;
            if (i_pop)
                r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop)
                r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_item;
    end

    assign o_full  = r_cnt == (FP_W + 1)'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];

endmodule
`default_nettype wire

// ----- rtl/core/dspm_modred.sv -----
`default_nettype none
module dspm_modred (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_value,
    input  wire logic [31:0] i_modulus,
    output logic             o_done,
    output logic [31:0]      o_result
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_val;
    logic [31:0] r_rem;
    logic [32:0] trial;
    logic [32:0] step;

    // restoring remainder, one dividend bit a cycle
    always_comb begin
        trial = {r_rem, r_val[63]};
        step  = (trial >= {1'b0, i_modulus}) ? trial - {1'b0, i_modulus} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[62:0], 1'b0};
            r_rem <= step[31:0];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_rem;

endmodule
`default_nettype wire

// ----- rtl/core/dspm_back.sv -----
`default_nettype none
module dspm_back import dspm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_modulus,
    input  wire logic        i_fifo_valid,
    input  wire t_item       i_item,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,
    output logic [0:0]       o_m_tuser
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_RD_DATA  = 16'b0000_0000_0000_0010,
        S_EMIT     = 16'b0000_0000_0000_0100,
        S_T_RE_GO  = 16'b0000_0000_0000_1000,
        S_T_RE_WT  = 16'b0000_0000_0001_0000,
        S_T_IM_GO  = 16'b0000_0000_0010_0000,
        S_T_IM_WT  = 16'b0000_0000_0100_0000,
        S_C_RD     = 16'b0000_0000_1000_0000,
        S_C_CHK    = 16'b0000_0001_0000_0000,
        S_P_MUL    = 16'b0000_0010_0000_0000,
        S_P_GO     = 16'b0000_0100_0000_0000,
        S_P_WT     = 16'b0000_1000_0000_0000,
        S_COMB     = 16'b0001_0000_0000_0000,
        S_ACC_RD   = 16'b0010_0000_0000_0000,
        S_ACC_WR   = 16'b0100_0000_0000_0000,
        S_NEXT     = 16'b1000_0000_0000_0000
    } t_state;

    function automatic logic [31:0] add_q(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] m);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        add_q = (s >= {1'b0, m}) ? 32'(s - {1'b0, m}) : s[31:0];
    endfunction

    function automatic logic [31:0] sub_q(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] m);
        sub_q = (a >= b) ? a - b : m - (b - a);
    endfunction

    t_state          r_state, n_state;
    logic            out_free;

    // stores
    logic [63:0]     r_dense [CELLS];
    logic [63:0]     r_dense_q;
    logic [63:0]     r_res_mem [CELLS];
    logic [63:0]     r_res_q;
    logic            r_res_qv;
    logic [CELLS-1:0] r_res_vld;
    logic [1:0]      r_term_x [MAX_TERMS];
    logic [1:0]      r_term_y [MAX_TERMS];
    logic [3:0]      r_term_w [MAX_TERMS];
    logic [63:0]     r_term_re [MAX_TERMS];
    logic [63:0]     r_term_im [MAX_TERMS];

    // sequencer
    logic [CNT_W-1:0] r_t, r_cnt;
    logic [X_W-1:0]  r_cx, r_cy;
    logic [W_W-1:0]  r_cw, r_k;
    logic [1:0]      r_pk;
    logic            r_neg, r_sub;
    logic [1:0]      r_tx, r_ty;
    logic [3:0]      r_tw;
    logic [31:0]     r_tr, r_ti;
    logic [63:0]     r_prod;
    logic [31:0]     r_pp [4];
    logic [31:0]     r_p_re, r_p_im;
    logic [IDX_W-1:0] r_dst, r_gw_idx, r_acc_addr;

    // output register
    logic            r_out_valid;
    logic            r_out_status;
    logic [31:0]     r_out_re, r_out_im;

    // strobes
    logic            emit, e_status;
    logic [31:0]     e_re, e_im;
    logic            dense_we, term_we, dense_re, res_re, res_we, clr;
    logic [IDX_W-1:0] res_raddr;
    logic            red_start, red_done;
    logic [63:0]     red_val;
    logic [31:0]     red_res;
    logic [63:0]     cur_term;
    logic [T_W-1:0]  t_idx;
    logic [IDX_W-1:0] dense_raddr;
    logic [31:0]     mul_a, mul_b;
    logic [31:0]     comb_re, comb_im, x_re, x_im, y_re, y_im;
    logic [X_W:0]    xd, yd;
    logic            xwrap, ywrap;
    logic [X_W-1:0]  gx, gy;
    logic [W_W+1:0]  gw;
    logic [31:0]     acc_old, acc_new;
    logic            last_cell;

    assign out_free    = !r_out_valid || i_m_tready;
    assign t_idx       = r_t[T_W-1:0];
    assign dense_raddr = IDX_W'((32'(r_cx) * DIM + 32'(r_cy)) * PHI + 32'(r_cw));
    assign last_cell   = (r_cw == W_W'(PHI - 1)) && (r_cy == X_W'(DIM - 1))
                      && (r_cx == X_W'(DIM - 1));

    always_comb begin
        cur_term = r_state == S_T_IM_GO ? r_term_im[t_idx] : r_term_re[t_idx];
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        emit      = 1'b0;
        e_status  = 1'b0;
        e_re      = '0;
        e_im      = '0;
        dense_we  = 1'b0;
        term_we   = 1'b0;
        dense_re  = 1'b0;
        res_re    = 1'b0;
        res_we    = 1'b0;
        res_raddr = r_dst + r_gw_idx;
        clr       = 1'b0;
        red_start = 1'b0;
        red_val   = r_prod;
        unique case (r_state)
            S_IDLE: begin
                if (i_fifo_valid && out_free) begin
                    o_pop = 1'b1;
                    unique case (i_item.op)
                        OP_LOAD_DENSE: begin
                            emit     = 1'b1;
                            e_status = i_item.rej;
                            dense_we = !i_item.rej;
                        end
                        OP_LOAD_TERM: begin
                            emit     = 1'b1;
                            e_status = i_item.rej;
                            term_we  = !i_item.rej;
                        end
                        OP_RUN: begin
                            if (i_item.rej) begin
                                emit     = 1'b1;
                                e_status = 1'b1;
                            end else begin
                                clr     = 1'b1;
                                n_state = i_item.term_count == '0 ? S_EMIT : S_T_RE_GO;
                            end
                        end
                        OP_READ: begin
                            if (i_item.rej) begin
                                emit     = 1'b1;
                                e_status = 1'b1;
                            end else begin
                                res_re    = 1'b1;
                                res_raddr = i_item.slot[IDX_W-1:0];
                                n_state   = S_RD_DATA;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD_DATA: begin
                emit    = 1'b1;
                e_re    = r_res_qv ? r_res_q[31:0]  : '0;
                e_im    = r_res_qv ? r_res_q[63:32] : '0;
                n_state = S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_T_RE_GO, S_T_IM_GO: begin
                red_start = 1'b1;
                red_val   = cur_term[63] ? 64'd0 - cur_term : cur_term;
                n_state   = r_state == S_T_RE_GO ? S_T_RE_WT : S_T_IM_WT;
            end
            S_T_RE_WT: if (red_done) n_state = S_T_IM_GO;
            S_T_IM_WT: if (red_done) n_state = S_C_RD;
            S_C_RD: begin
                dense_re = 1'b1;
                n_state  = S_C_CHK;
            end
            S_C_CHK:   n_state = r_dense_q == '0 ? S_NEXT : S_P_MUL;
            S_P_MUL:   n_state = S_P_GO;
            S_P_GO: begin
                red_start = 1'b1;
                n_state   = S_P_WT;
            end
            S_P_WT: if (red_done) n_state = r_pk == 2'd3 ? S_COMB : S_P_MUL;
            S_COMB:    n_state = S_ACC_RD;
            S_ACC_RD: begin
                res_re    = 1'b1;
                res_raddr = r_dst + (r_sub ? IDX_W'(r_k) : r_gw_idx);
                n_state   = S_ACC_WR;
            end
            S_ACC_WR: begin
                res_we  = 1'b1;
                n_state = (!r_sub || r_k == W_W'(PHI - 1)) ? S_NEXT : S_ACC_RD;
            end
            S_NEXT: begin
                if (!last_cell)
                    n_state = S_C_RD;
                else if (r_t + 1'b1 == r_cnt)
                    n_state = S_EMIT;
                else
                    n_state = S_T_RE_GO;
            end
            default: n_state = S_IDLE;
        endcase
    end

    dspm_modred u_modred (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (red_start),
        .i_value   (red_val),
        .i_modulus (i_modulus),
        .o_done    (red_done),
        .o_result  (red_res)
    );

    // product operands: re*tr, im*ti, re*ti, im*tr
    always_comb begin
        case (r_pk)
            2'd0:    begin mul_a = r_dense_q[31:0];  mul_b = r_tr; end
            2'd1:    begin mul_a = r_dense_q[63:32]; mul_b = r_ti; end
            2'd2:    begin mul_a = r_dense_q[31:0];  mul_b = r_ti; end
            default: begin mul_a = r_dense_q[63:32]; mul_b = r_tr; end
        endcase
    end

    // combine partial products, fold in the wraps and the target slot
    always_comb begin
        comb_re = sub_q(r_pp[0], r_pp[1], i_modulus);
        comb_im = add_q(r_pp[2], r_pp[3], i_modulus);
        xd      = {1'b0, r_cx} + (X_W + 1)'(r_tx);
        yd      = {1'b0, r_cy} + (X_W + 1)'(r_ty);
        xwrap   = 32'(xd) >= 32'(DIM);
        ywrap   = 32'(yd) >= 32'(DIM);
        gx      = xwrap ? X_W'(32'(xd) - 32'(DIM)) : X_W'(xd);
        gy      = ywrap ? X_W'(32'(yd) - 32'(DIM)) : X_W'(yd);
        x_re    = xwrap ? (comb_im == '0 ? '0 : i_modulus - comb_im) : comb_re;
        x_im    = xwrap ? comb_re : comb_im;
        y_re    = ywrap ? (x_im == '0 ? '0 : i_modulus - x_im) : x_re;
        y_im    = ywrap ? x_re : x_im;
        gw      = (W_W + 2)'(r_cw) + (W_W + 2)'(r_tw);
        if (32'(gw) >= 32'(PRIME))
            gw = gw - (W_W + 2)'(PRIME);
    end

    always_comb begin
        acc_old = r_res_qv ? r_res_q[31:0] : '0;
        acc_new = r_sub ? sub_q(acc_old, r_p_re, i_modulus)
                        : add_q(acc_old, r_p_re, i_modulus);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_res_vld   <= '0;
        end else begin
            r_state <= n_state;
            if (emit)
                r_out_valid <= 1'b1;
            else if (i_m_tready)
                r_out_valid <= 1'b0;
            if (clr)
                r_res_vld <= '0;
            else if (res_we)
                r_res_vld[r_acc_addr] <= 1'b1;
        end
    end

    // dense and result memories
    always_ff @(posedge i_clk) begin
        if (dense_we)
            r_dense[i_item.slot[IDX_W-1:0]] <= {i_item.coef_imag, i_item.coef_real};
        if (dense_re)
            r_dense_q <= r_dense[dense_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (res_we)
            r_res_mem[r_acc_addr] <= {
                r_sub ? sub_q(r_res_qv ? r_res_q[63:32] : '0, r_p_im, i_modulus)
                      : add_q(r_res_qv ? r_res_q[63:32] : '0, r_p_im, i_modulus),
                acc_new};
        if (res_re) begin
            r_res_q  <= r_res_mem[res_raddr];
            r_res_qv <= r_res_vld[res_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (term_we) begin
            r_term_x[i_item.slot[T_W-1:0]]  <= i_item.term_x;
            r_term_y[i_item.slot[T_W-1:0]]  <= i_item.term_y;
            r_term_w[i_item.slot[T_W-1:0]]  <= i_item.term_w;
            r_term_re[i_item.slot[T_W-1:0]] <= i_item.term_re;
            r_term_im[i_item.slot[T_W-1:0]] <= i_item.term_im;
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_status <= e_status;
            r_out_re     <= e_re;
            r_out_im     <= e_im;
        end
        unique case (r_state)
            S_IDLE: begin
                r_cnt <= i_item.term_count;
                r_t   <= '0;
                r_cx  <= '0;
                r_cy  <= '0;
                r_cw  <= '0;
            end
            S_T_RE_GO, S_T_IM_GO: begin
                r_neg <= cur_term[63];
                r_tx  <= r_term_x[t_idx];
                r_ty  <= r_term_y[t_idx];
                r_tw  <= r_term_w[t_idx];
            end
            S_T_RE_WT: if (red_done)
                r_tr <= (r_neg && red_res != '0) ? i_modulus - red_res : red_res;
            S_T_IM_WT: if (red_done)
                r_ti <= (r_neg && red_res != '0) ? i_modulus - red_res : red_res;
            S_C_CHK: r_pk <= '0;
            S_P_MUL: r_prod <= 64'(mul_a) * 64'(mul_b);
            S_P_WT: if (red_done) begin
                r_pp[r_pk] <= red_res;
                r_pk       <= r_pk + 1'b1;
            end
            S_COMB: begin
                r_p_re   <= y_re;
                r_p_im   <= y_im;
                r_dst    <= IDX_W'((32'(gx) * DIM + 32'(gy)) * PHI);
                r_sub    <= 32'(gw) >= 32'(PHI);
                r_gw_idx <= IDX_W'(gw);
                r_k      <= '0;
            end
            S_ACC_RD: r_acc_addr <= res_raddr;
            S_ACC_WR: r_k <= r_k + 1'b1;
            S_NEXT: begin
                r_cw <= r_cw == W_W'(PHI - 1) ? '0 : r_cw + 1'b1;
                if (r_cw == W_W'(PHI - 1)) begin
                    r_cy <= r_cy == X_W'(DIM - 1) ? '0 : r_cy + 1'b1;
                    if (r_cy == X_W'(DIM - 1))
                        r_cx <= r_cx == X_W'(DIM - 1) ? '0 : r_cx + 1'b1;
                end
                if (last_cell)
                    r_t <= r_t + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_im, r_out_re};
    assign o_m_tuser  = r_out_status;

endmodule
`default_nettype wire

// ----- rtl/core/dense_sparse_gaussian_poly_mul_modq.sv -----
`default_nettype none
// Dense-by-sparse Gaussian polynomial product mod q. Requests enter on the
// s stream with the opcode in tuser; each gives one response on the m stream
// (status in tuser, real and imaginary residues in tdata). A front end checks
// ranges and queues up to two requests, so input is taken while the back end
// works. A run clears the result store, then per term reduces the signed
// coefficient in the bit-serial remainder unit, and per nonzero dense
// coefficient forms four 32x32 products, each reduced by that one shared
// unit, then accumulates into its target slot, or subtracts from all PHI
// slots of the target cell when the W exponent wraps to PHI; a zero
// coefficient is skipped. The modulus port is always ready; write it only
// while the block is idle.
module dense_sparse_gaussian_poly_mul_modq import dspm_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // slot, coef_real, coef_imag, term_x, term_y, term_w, term_re, term_im, term_count
    input  wire logic [215:0] i_s_tdata,
    // opcode
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // out_real, out_imag
    output logic [63:0]       o_m_tdata,
    // status
    output logic [0:0]        o_m_tuser,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [31:0]  i_cfg_data
);

    logic [31:0] r_modulus;
    logic        fifo_full, fifo_valid, push, pop;
    t_item       in_item, head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_modulus <= MOD_RESET;
        else if (i_cfg_valid && i_cfg_data >= MOD_MIN)
            r_modulus <= i_cfg_data;
    end

    assign o_cfg_ready = 1'b1;

    dspm_front u_front (
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_modulus   (r_modulus),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_item      (in_item)
    );

    dspm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_item  (head_item)
    );

    dspm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_modulus    (r_modulus),
        .i_fifo_valid (fifo_valid),
        .i_item       (head_item),
        .o_pop        (pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

endmodule
`default_nettype wire

// ----- tb/sv/dense_sparse_gaussian_poly_mul_modq_checker.sv -----
`timescale 1ns / 100ps
module dense_sparse_gaussian_poly_mul_modq_checker import dspm_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    // slot, coef_real, coef_imag, term_x, term_y, term_w, term_re, term_im, term_count
    input  wire logic [215:0] i_s_tdata,
    // opcode
    input  wire logic [1:0]   i_s_tuser,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    // out_real, out_imag
    input  wire logic [63:0]  i_m_tdata,
    // status
    input  wire logic [0:0]   i_m_tuser,
    input  wire logic         i_cfg_valid,
    input  wire logic         i_cfg_ready,
    input  wire logic [31:0]  i_cfg_data,
    output int                o_failures,
    output int                o_pending
);

    typedef struct packed {
        logic        status;
        logic [31:0] res_re;
        logic [31:0] res_im;
    } t_response;

    bit [63:0] q_now;
    bit [31:0] dense_re [CELLS];
    bit [31:0] dense_im [CELLS];
    bit [63:0] prod_re [CELLS];
    bit [63:0] prod_im [CELLS];
    bit [1:0]  tx_store [MAX_TERMS];
    bit [1:0]  ty_store [MAX_TERMS];
    bit [3:0]  tw_store [MAX_TERMS];
    bit [63:0] tre_store [MAX_TERMS];
    bit [63:0] tim_store [MAX_TERMS];
    t_response awaited_responses [$];

    function automatic bit [63:0] addq(bit [63:0] a, bit [63:0] b);
        bit [63:0] s;
        s = a + b;
        return (s >= q_now) ? s - q_now : s;
    endfunction

    function automatic bit [63:0] subq(bit [63:0] a, bit [63:0] b);
        return (a >= b) ? a - b : q_now - (b - a);
    endfunction

    function automatic bit [63:0] mulq(bit [63:0] a, bit [63:0] b);
        return ({32'd0, a[31:0]} * {32'd0, b[31:0]}) % q_now;
    endfunction

    function automatic bit [63:0] reduce_signed(bit [63:0] v);
        bit [63:0] mag;
        bit [63:0] r;
        mag = v[63] ? (64'd0 - v) : v;
        r = mag % q_now;
        if (v[63] && r != 0)
            r = q_now - r;
        return r;
    endfunction

    // complex multiply-accumulate of every nonzero dense cell by each term
    function automatic void multiply_sparse(int count);
        bit [63:0] tr, ti, pr, pi, tmp;
        int gx, gy, gw, base, idx;
        bit xw, yw;
        foreach (prod_re[c]) begin
            prod_re[c] = 0;
            prod_im[c] = 0;
        end
        for (int t = 0; t < count; t++) begin
            tr = reduce_signed(tre_store[t]);
            ti = reduce_signed(tim_store[t]);
            for (int x = 0; x < DIM; x++) begin
                gx = x + tx_store[t];
                xw = gx >= DIM;
                if (xw) gx -= DIM;
                for (int y = 0; y < DIM; y++) begin
                    gy = y + ty_store[t];
                    yw = gy >= DIM;
                    if (yw) gy -= DIM;
                    for (int w = 0; w < PHI; w++) begin
                        idx = (x * DIM + y) * PHI + w;
                        if (dense_re[idx] == 0 && dense_im[idx] == 0)
                            continue;
                        pr = subq(mulq(dense_re[idx], tr), mulq(dense_im[idx], ti));
                        pi = addq(mulq(dense_re[idx], ti), mulq(dense_im[idx], tr));
                        // each wrap multiplies by i
                        if (xw) begin
                            tmp = (pi == 0) ? 0 : q_now - pi;
                            pi = pr;
                            pr = tmp;
                        end
                        if (yw) begin
                            tmp = (pi == 0) ? 0 : q_now - pi;
                            pi = pr;
                            pr = tmp;
                        end
                        gw = w + tw_store[t];
                        if (gw >= PRIME) gw -= PRIME;
                        base = (gx * DIM + gy) * PHI;
                        if (gw < PHI) begin
                            prod_re[base + gw] = addq(prod_re[base + gw], pr);
                            prod_im[base + gw] = addq(prod_im[base + gw], pi);
                        end else begin
                            // W^PHI folds onto every W slot with minus sign
                            for (int k = 0; k < PHI; k++) begin
                                prod_re[base + k] = subq(prod_re[base + k], pr);
                                prod_im[base + k] = subq(prod_im[base + k], pi);
                            end
                        end
                    end
                end
            end
        end
    endfunction

    function automatic t_response predict_response(t_op op, logic [215:0] d);
        t_response r;
        bit [7:0]  slot;
        bit [31:0] cr, ci;
        bit [4:0]  cnt;
        slot = d[7:0];
        cr = d[39:8];
        ci = d[71:40];
        cnt = d[212:208];
        r = '0;
        case (op)
            OP_LOAD_DENSE: begin
                if (slot >= CELLS || cr >= q_now || ci >= q_now) begin
                    r.status = 1'b1;
                end else begin
                    dense_re[slot] = cr;
                    dense_im[slot] = ci;
                end
            end
            OP_LOAD_TERM: begin
                if (slot >= MAX_TERMS || d[73:72] >= DIM || d[75:74] >= DIM
                        || d[79:76] >= PHI) begin
                    r.status = 1'b1;
                end else begin
                    tx_store[slot] = d[73:72];
                    ty_store[slot] = d[75:74];
                    tw_store[slot] = d[79:76];
                    tre_store[slot] = d[143:80];
                    tim_store[slot] = d[207:144];
                end
            end
            OP_RUN: begin
                if (cnt > MAX_TERMS)
                    r.status = 1'b1;
                else
                    multiply_sparse(cnt);
            end
            default: begin
                if (slot >= CELLS) begin
                    r.status = 1'b1;
                end else begin
                    r.res_re = prod_re[slot][31:0];
                    r.res_im = prod_im[slot][31:0];
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        o_failures++;
    endtask

    t_response got_rsp, want_rsp;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            q_now = MOD_RESET;
            foreach (prod_re[c]) begin
                prod_re[c] = 0;
                prod_im[c] = 0;
            end
            awaited_responses.delete();
            o_failures = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_rsp = {i_m_tuser[0], i_m_tdata[31:0], i_m_tdata[63:32]};
                if (awaited_responses.size() == 0) begin
                    report_mismatch("unexpected response",
                                    {got_rsp.res_im, got_rsp.res_re}, 0);
                end else begin
                    want_rsp = awaited_responses.pop_front();
                    if (got_rsp.status !== want_rsp.status)
                        report_mismatch("status", got_rsp.status, want_rsp.status);
                    if (got_rsp.res_re !== want_rsp.res_re)
                        report_mismatch("out_real", got_rsp.res_re, want_rsp.res_re);
                    if (got_rsp.res_im !== want_rsp.res_im)
                        report_mismatch("out_imag", got_rsp.res_im, want_rsp.res_im);
                end
            end
            if (i_cfg_valid && i_cfg_ready && i_cfg_data >= MOD_MIN)
                q_now = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                awaited_responses.insert(awaited_responses.size(),
                    predict_response(t_op'(i_s_tuser), i_s_tdata));
        end
        o_pending = awaited_responses.size();
    end

endmodule

// ----- tb/sv/dense_sparse_gaussian_poly_mul_modq_tb.sv -----
`timescale 1ns / 100ps
module dense_sparse_gaussian_poly_mul_modq_tb import dspm_pkg::*;;

    localparam int IDLE_LIMIT = 200000;
    localparam int MAX_LIVE   = 6;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [215:0] s_tdata = '0;
    logic [1:0]   s_tuser = OP_READ;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;
    int           failures;
    int           pending;

    bit [31:0]    q_now = MOD_RESET;
    int           hold_request = 0;
    int           idle_cycles = 0;
    bit [7:0]     live_cells [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    dense_sparse_gaussian_poly_mul_modq u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    dense_sparse_gaussian_poly_mul_modq_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    // watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // response side backpressure, with an optional long hold
    initial begin : sink
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                m_tready <= 1'b0;
                repeat (hold_request) @(negedge i_clk);
                hold_request = 0;
                m_tready <= 1'b1;
            end else begin
                stall = $urandom_range(0, 99);
                if (stall < 70) begin
                    m_tready <= 1'b1;
                    if (stall < 8) repeat ($urandom_range(20, 80)) @(negedge i_clk);
                end else begin
                    m_tready <= 1'b0;
                    if (stall >= 97) repeat ($urandom_range(10, 40)) @(negedge i_clk);
                    else repeat ($urandom_range(0, 2)) @(negedge i_clk);
                end
            end
        end
    end

    task automatic send_request(t_op op, bit [7:0] slot, bit [31:0] cr, bit [31:0] ci,
                                bit [7:0] exps, bit [63:0] tre, bit [63:0] tim,
                                bit [4:0] cnt, bit no_gap);
        int gap;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b0, cnt, tim, tre, exps, ci, cr, slot};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        gap = $urandom_range(0, 99);
        if (no_gap || gap < 60) gap = 0;
        else if (gap < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_modulus(bit [31:0] value);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        if (value >= MOD_MIN) q_now = value;
    endtask

    function automatic bit [31:0] pick_residue();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return (q_now > 1) ? $urandom_range(q_now - 1, 1) : 1;
        if (k == 6) return q_now - 1;
        if (k == 7) return q_now;
        if (k == 8) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic bit [63:0] pick_term_coef();
        case ($urandom_range(0, 7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            3: return 64'd0;
            4: return 64'($signed($urandom_range(0, 200)) - 100);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // keep few nonzero dense cells so that runs stay short
    task automatic load_dense_random();
        bit [7:0] slot;
        bit [31:0] cr, ci;
        int n;
        if (live_cells.size() >= MAX_LIVE && $urandom_range(0, 1)) begin
            n = $urandom_range(0, live_cells.size() - 1);
            slot = live_cells[n];
            live_cells.delete(n);
            send_request(OP_LOAD_DENSE, slot, 0, 0, 0, 0, 0, 0, 0);
            return;
        end
        slot = 8'($urandom_range(0, 255));
        n = -1;
        foreach (live_cells[j]) if (live_cells[j] == slot) n = j;
        if (n < 0 && live_cells.size() >= MAX_LIVE) begin
            cr = 0;
            ci = 0;
        end else begin
            cr = ($urandom_range(0, 3) == 0) ? 0 : pick_residue();
            ci = ($urandom_range(0, 3) == 0) ? 0 : pick_residue();
            if (n < 0 && (cr != 0 || ci != 0)) live_cells.insert(live_cells.size(), slot);
        end
        send_request(OP_LOAD_DENSE, slot, cr, ci, 8'($urandom), 64'($urandom),
                     64'($urandom), 5'($urandom), 0);
    endtask

    task automatic load_term_random();
        bit [7:0] slot;
        slot = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 255))
                                            : 8'($urandom_range(0, 15));
        send_request(OP_LOAD_TERM, slot, $urandom, $urandom, 8'($urandom),
                     pick_term_coef(), pick_term_coef(), 5'($urandom), 0);
    endtask

    task automatic run_random();
        bit [4:0] cnt;
        int k;
        k = $urandom_range(0, 23);
        if (k == 0) cnt = 16;
        else if (k < 3) cnt = 5'($urandom_range(17, 31));
        else cnt = 5'($urandom_range(0, 3));
        send_request(OP_RUN, 8'($urandom), $urandom, $urandom, 8'($urandom),
                     64'($urandom), 64'($urandom), cnt, 0);
    endtask

    bit [31:0] moduli [8] = '{32'hFFFF_FFFF, 32'd2, 32'd3, 32'd1, 32'h8000_0000,
                              32'd0, 32'd65537, 32'd12289};

    initial begin : stimulus
        int k;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every dense cell and term slot gets written before any run
        for (int c = 0; c < CELLS; c++)
            send_request(OP_LOAD_DENSE, 8'(c), 0, 0, 0, 0, 0, 0, 1);
        for (int t = 0; t < MAX_TERMS; t++)
            send_request(OP_LOAD_TERM, 8'(t), 0, 0, 8'($urandom), pick_term_coef(),
                         pick_term_coef(), 0, 0);

        // extremes and rejections
        send_request(OP_LOAD_TERM, 0, 0, 0, 8'hFF, 64'h8000_0000_0000_0000,
                     64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
        send_request(OP_LOAD_TERM, 1, 0, 0, 8'h00, 0, 0, 0, 0);
        send_request(OP_LOAD_TERM, 16, 0, 0, 0, 1, 1, 0, 0);
        send_request(OP_LOAD_TERM, 255, 0, 0, 0, 1, 1, 0, 0);
        send_request(OP_LOAD_DENSE, 0, 32'd65536, 32'd65536, 0, 0, 0, 0, 0);
        send_request(OP_LOAD_DENSE, 255, 32'd1, 32'd65535, 0, 0, 0, 0, 0);
        send_request(OP_LOAD_DENSE, 17, 32'd65537, 32'd1, 0, 0, 0, 0, 0);
        send_request(OP_LOAD_DENSE, 18, 32'd1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        live_cells = '{8'd0, 8'd255};
        send_request(OP_RUN, 0, 0, 0, 0, 0, 0, 5'd0, 0);
        send_request(OP_RUN, 0, 0, 0, 0, 0, 0, 5'd2, 0);
        send_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(OP_READ, 255, 0, 0, 0, 0, 0, 0, 0);
        send_request(OP_RUN, 0, 0, 0, 0, 0, 0, 5'd16, 0);
        send_request(OP_RUN, 0, 0, 0, 0, 0, 0, 5'd17, 0);
        send_request(OP_RUN, 0, 0, 0, 0, 0, 0, 5'd31, 0);
        for (int c = 0; c < 8; c++)
            send_request(OP_READ, 8'($urandom), 0, 0, 0, 0, 0, 0, 0);

        for (int phase = 0; phase < 8; phase++) begin
            write_modulus(moduli[phase]);
            if (phase == 1) hold_request = 600;
            for (int n = 0; n < 132; n++) begin
                k = $urandom_range(0, 99);
                if (k < 40) load_dense_random();
                else if (k < 58) load_term_random();
                else if (k < 63) run_random();
                else send_request(OP_READ, 8'($urandom), $urandom, $urandom,
                                  8'($urandom), 64'($urandom), 64'($urandom),
                                  5'($urandom), 0);
                if (phase == 3 && n == 80) begin
                    @(negedge i_clk);
                    s_tvalid <= 1'b0;
                    wait (pending == 0);
                end
            end
        end

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
